// ----- design/sphm_pkg.sv -----
// Package for the SPH particle mass block: register indexes, fixed-point constants
// and the control types between the sequencer and the root/divide unit.
// No dependencies.
package sphm_pkg;
	localparam int FRAC_BITS = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_H    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RHO0     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAMMA_B  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GAMMA_F  = 3'd6;

	localparam logic MODE_BOUNDARY = 1'b0;
	localparam logic MODE_FLUID    = 1'b1;

	// Fluid correction factor 0.99913897808 in Q0.32.
	localparam logic [31:0] FLUID_C32 = 32'd4291269235;
	localparam logic [60:0] DEN_CAP   = 61'h1000_0000_0000_0000;
	localparam logic [47:0] SUM_MAX   = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic start;
		logic is_div;
	} rd_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rd_stat_t;
endpackage

// ----- design/sphm_ifs.sv -----
// Channel interfaces of the SPH particle mass block: candidate input, result output
// and configuration write. Uses sphm_pkg.
interface sphm_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] offset_x;
	logic signed [31:0] offset_y;
	logic signed [31:0] offset_z;
	logic               neighbour_is_boundary;
	logic               last_candidate;
	modport source (output valid, offset_x, offset_y, offset_z, neighbour_is_boundary,
		last_candidate, input ready);
	modport sink (input valid, offset_x, offset_y, offset_z, neighbour_is_boundary,
		last_candidate, output ready);
endinterface

interface sphm_out_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [31:0] neighbour_distance;
	logic [31:0] kernel_weight;
	logic        mass_valid;
	logic [31:0] particle_mass;
	modport source (output valid, accepted, neighbour_distance, kernel_weight, mass_valid,
		particle_mass, input ready);
	modport sink (input valid, accepted, neighbour_distance, kernel_weight, mass_valid,
		particle_mass, output ready);
endinterface

interface sphm_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sphm_pkg::CFG_IDX_W-1:0] index;
	logic [31:0]                      data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/sph_particle_mass_from_kernel_sum.sv -----
// Channel  | Direction | Moves
// in_ch    | sink      | one candidate offset per transfer, with boundary and last flags
// out_ch   | source    | acceptance, distance, kernel weight and mass of that candidate
// cfg      | sink      | register index and data, always ready
// A rejected candidate passes from one input transfer to the next through an idle state,
// the squares, the square root in the root/divide unit, the sum update and the result.
// An accepted candidate adds the kernel evaluation; the last candidate adds the boundary
// or fluid multiplier steps and a division in the root/divide unit.
// These steps use the single multiplier and the one-bit-per-cycle root/divide unit.
// Reset clears the kernel sum and loads the register defaults. A stalled result holds the
// block until its transfer.
// Uses sphm_pkg, sphm_ifs, sphm_mul and sphm_rootdiv.
module sph_particle_mass_from_kernel_sum (
	input  logic       clk,
	input  logic       arst_n,
	sphm_in_if.sink    in_ch,
	sphm_out_if.source out_ch,
	sphm_cfg_if.sink   cfg
);
	localparam int F = sphm_pkg::FRAC_BITS;
	localparam logic [47:0] ONE = 48'd1 << F;

	typedef enum logic [4:0] {
		S_IDLE, S_SQX, S_SQY, S_SQZ, S_SQS, S_ROOT, S_D, S_T, S_C2A, S_C2B, S_C1A, S_C1B,
		S_P, S_W, S_WS, S_END, S_BM, S_BD, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7,
		S_DIV, S_OUT
	} state_t;

	state_t state_q;
	logic        mode_q;
	logic [31:0] radius_q, inv_h_q, alpha_q, rho0_q, gamma_b_q, gamma_f_q;
	logic [47:0] sum_q;
	logic [31:0] ax_q, ay_q, az_q;
	logic        nb_q, last_q, acc_q;
	logic [63:0] sos_q, p_lo_q, hi_q, den2_q;
	logic [31:0] dist_q, weight_q, mass_q;
	logic [17:0] t1_q, t2_q;
	logic [19:0] c2_q, poly_q;
	logic [60:0] den_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_q;
	sphm_pkg::rd_cmd_t  rd_cmd;
	sphm_pkg::rd_stat_t rd_stat;
	logic [63:0] rd_num, rd_den;
	logic [31:0] rd_res;

	logic [47:0] d48;
	logic [19:0] c1;
	logic [48:0] sum_next;
	logic [60:0] den_raw;
	logic        acc_now;

	sphm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(mul_q));

	sphm_rootdiv u_rootdiv (
		.clk(clk), .arst_n(arst_n), .cmd(rd_cmd), .num(rd_num), .den(rd_den),
		.stat(rd_stat), .res(rd_res)
	);

	function automatic logic [31:0] mag(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	assign d48 = mul_q[63:F];
	assign c1 = {mul_q[F+17:F], 2'b00};
	assign sum_next = {1'b0, sum_q} + {17'd0, weight_q};
	assign den_raw = {1'b0, mul_q[43:0], 16'd0} + {13'd0, p_lo_q[63:F]};
	assign acc_now = (rd_res < radius_q) && (mode_q == sphm_pkg::MODE_FLUID || nb_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQX: begin mul_a = ax_q; mul_b = ax_q; end
			S_SQY: begin mul_a = ay_q; mul_b = ay_q; end
			S_SQZ: begin mul_a = az_q; mul_b = az_q; end
			S_D:   begin mul_a = dist_q; mul_b = inv_h_q; end
			S_C2A: begin mul_a = {14'd0, t2_q}; mul_b = {14'd0, t2_q}; end
			S_C2B: begin mul_a = mul_q[F+31:F]; mul_b = {14'd0, t2_q}; end
			S_C1A: begin mul_a = {14'd0, t1_q}; mul_b = {14'd0, t1_q}; end
			S_C1B: begin mul_a = mul_q[F+31:F]; mul_b = {14'd0, t1_q}; end
			S_W:   begin mul_a = {12'd0, poly_q}; mul_b = alpha_q; end
			S_BM:  begin mul_a = gamma_b_q; mul_b = rho0_q; end
			S_F1:  begin mul_a = gamma_f_q; mul_b = sum_q[31:0]; end
			S_F2:  begin mul_a = gamma_f_q; mul_b = {16'd0, sum_q[47:32]}; end
			S_F4:  begin mul_a = {3'd0, den_q[60:32]}; mul_b = sphm_pkg::FLUID_C32; end
			S_F5:  begin mul_a = den_q[31:0]; mul_b = sphm_pkg::FLUID_C32; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		rd_cmd.start  = 1'b0;
		rd_cmd.is_div = 1'b0;
		rd_num = sos_q + mul_q;
		rd_den = '0;
		unique case (state_q)
			S_SQS: rd_cmd.start = 1'b1;
			S_BD: begin
				rd_cmd.start = 1'b1; rd_cmd.is_div = 1'b1;
				rd_num = mul_q; rd_den = {16'd0, sum_q};
			end
			S_F7: begin
				rd_cmd.start = 1'b1; rd_cmd.is_div = 1'b1;
				rd_num = {16'd0, rho0_q, 16'd0}; rd_den = den2_q;
			end
			default: rd_cmd.start = 1'b0;
		endcase
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= sphm_pkg::MODE_BOUNDARY;
			radius_q  <= 32'd131072;
			inv_h_q   <= 32'd65536;
			alpha_q   <= 32'd65536;
			rho0_q    <= 32'd65536000;
			gamma_b_q <= 32'd65536;
			gamma_f_q <= 32'd65536;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				sphm_pkg::REG_MODE:    mode_q    <= cfg.data[0];
				sphm_pkg::REG_RADIUS:  radius_q  <= cfg.data;
				sphm_pkg::REG_INV_H:   inv_h_q   <= cfg.data;
				sphm_pkg::REG_ALPHA:   alpha_q   <= cfg.data;
				sphm_pkg::REG_RHO0:    rho0_q    <= cfg.data;
				sphm_pkg::REG_GAMMA_B: gamma_b_q <= cfg.data;
				sphm_pkg::REG_GAMMA_F: gamma_f_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sum_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_ch.valid) begin
					ax_q <= mag(in_ch.offset_x);
					ay_q <= mag(in_ch.offset_y);
					az_q <= mag(in_ch.offset_z);
					nb_q <= in_ch.neighbour_is_boundary;
					last_q <= in_ch.last_candidate;
					weight_q <= '0;
					mass_q <= '0;
					state_q <= S_SQX;
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: begin sos_q <= mul_q; state_q <= S_SQZ; end
				S_SQZ: begin sos_q <= sos_q + mul_q; state_q <= S_SQS; end
				S_SQS: state_q <= S_ROOT;
				S_ROOT: if (rd_stat.done) begin
					dist_q <= rd_res;
					acc_q <= acc_now;
					state_q <= acc_now ? S_D : S_END;
				end
				S_D: state_q <= S_T;
				S_T: begin
					t1_q <= (d48 < ONE) ? 18'(ONE - d48) : 18'd0;
					t2_q <= (d48 < 2 * ONE) ? 18'(2 * ONE - d48) : 18'd0;
					state_q <= S_C2A;
				end
				S_C2A: state_q <= S_C2B;
				S_C2B: state_q <= S_C1A;
				S_C1A: begin c2_q <= mul_q[F+19:F]; state_q <= S_C1B; end
				S_C1B: state_q <= S_P;
				S_P: begin
					poly_q <= (c2_q > c1) ? c2_q - c1 : 20'd0;
					state_q <= S_W;
				end
				S_W: state_q <= S_WS;
				S_WS: begin
					weight_q <= (mul_q[63:F+32] != '0) ? 32'hFFFF_FFFF : mul_q[F+31:F];
					state_q <= S_END;
				end
				S_END: begin
					// The weight register holds zero for a rejected candidate.
					sum_q <= sum_next[48] ? sphm_pkg::SUM_MAX : sum_next[47:0];
					if (!last_q) state_q <= S_OUT;
					else state_q <= (mode_q == sphm_pkg::MODE_FLUID) ? S_F1 : S_BM;
				end
				S_BM: state_q <= S_BD;
				S_BD: state_q <= S_DIV;
				S_F1: state_q <= S_F2;
				S_F2: begin p_lo_q <= mul_q; state_q <= S_F3; end
				S_F3: begin
					if (mul_q[47:44] != 4'd0 || den_raw > sphm_pkg::DEN_CAP)
						den_q <= sphm_pkg::DEN_CAP;
					else
						den_q <= den_raw;
					state_q <= S_F4;
				end
				S_F4: state_q <= S_F5;
				S_F5: begin hi_q <= mul_q; state_q <= S_F6; end
				S_F6: begin den2_q <= hi_q + {32'd0, mul_q[63:32]}; state_q <= S_F7; end
				S_F7: state_q <= S_DIV;
				S_DIV: if (rd_stat.done) begin
					mass_q <= rd_res;
					sum_q <= '0;
					state_q <= S_OUT;
				end
				S_OUT: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ch.ready = state_q == S_IDLE;
	assign out_ch.valid = state_q == S_OUT;
	assign out_ch.accepted = acc_q;
	assign out_ch.neighbour_distance = dist_q;
	assign out_ch.kernel_weight = weight_q;
	assign out_ch.mass_valid = last_q;
	assign out_ch.particle_mass = mass_q;

	a_idle_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !rd_stat.busy && !out_ch.valid)
		else $error("input taken while unit busy or result pending");
	a_mass_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.mass_valid |-> out_ch.particle_mass == 32'd0)
		else $error("mass reported on a non-final candidate");
	a_weight_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.accepted |-> out_ch.kernel_weight == 32'd0)
		else $error("weight reported for a rejected candidate");
	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.mass_valid |-> sum_q == 48'd0)
		else $error("kernel sum not cleared after final candidate");
endmodule

// ----- design/sphm_mul.sv -----
// Shared 32x32 unsigned multiplier with a registered product.
// No dependencies.
module sphm_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p_q
);
	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end
endmodule

// ----- design/sphm_rootdiv.sv -----
// Iterative unit, one result bit per cycle: 64-bit integer square root or 64/64
// division with a 32-bit saturating quotient. One shared compare and subtract.
// Uses sphm_pkg.
module sphm_rootdiv (
	input  logic              clk,
	input  logic              arst_n,
	input  sphm_pkg::rd_cmd_t cmd,
	input  logic [63:0]       num,
	input  logic [63:0]       den,
	output sphm_pkg::rd_stat_t stat,
	output logic [31:0]       res
);
	logic [63:0] rem_q, src_q, den_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q, is_div_q, sat_q, zero_q;
	logic [63:0] shifted, trial;
	logic        ge;

	always_comb begin
		if (is_div_q) begin
			shifted = {rem_q[62:0], src_q[63]};
			trial   = den_q;
		end else begin
			shifted = {rem_q[61:0], src_q[63:62]};
			trial   = {30'd0, root_q, 2'b01};
		end
		ge = shifted >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			is_div_q <= cmd.is_div;
			den_q    <= den;
			root_q   <= '0;
			zero_q   <= num == 64'd0;
			// A quotient of 2^32 or more shows already in the upper half.
			sat_q    <= ({32'd0, num[63:32]} >= den) && (num != 64'd0);
			if (cmd.is_div) begin
				rem_q <= {32'd0, num[63:32]};
				src_q <= {num[31:0], 32'd0};
			end else begin
				rem_q <= '0;
				src_q <= num;
			end
		end else if (busy_q) begin
			rem_q  <= ge ? shifted - trial : shifted;
			root_q <= {root_q[30:0], ge};
			src_q  <= is_div_q ? {src_q[62:0], 1'b0} : {src_q[61:0], 2'b00};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign res = !is_div_q ? root_q : (zero_q ? 32'd0 : (sat_q ? 32'hFFFF_FFFF : root_q));
endmodule
